// File: rtl/dsc_pkg.sv
// Shared types and constants of the dispense session controller.
// No dependencies; imported by dsc_poll_eval and the core top level.
package dsc_pkg;

	// Session phases
	typedef enum logic [1:0] {
		PH_NOCARD    = 2'd0,
		PH_DETECTED  = 2'd1,
		PH_TOLERANCE = 2'd2,
		PH_LOADING   = 2'd3
	} phase_t;

	// Result kinds
	localparam logic [1:0] KIND_STATUS = 2'd0;
	localparam logic [1:0] KIND_SNAP   = 2'd1;
	localparam logic [1:0] KIND_LOAD   = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_TOLERANCE = 2'd0;
	localparam logic [1:0] CFG_TANK      = 2'd1;

	localparam logic [15:0] TOLERANCE_RST = 16'd1000;
	localparam logic [31:0] SNAP_FILL     = 32'd65535;

	// Milliseconds to seconds: drop three bits (divide by 8), then divide by
	// 125 through a reciprocal, ceil(2^36 / 125), exact for 29-bit operands.
	localparam int             MS_PRESHIFT = 3;
	localparam int             RECIP_W     = 30;
	localparam logic [29:0]    RECIP_125   = 30'd549755814;
	localparam int             RECIP_SHIFT = 36;
	localparam int             PROD_W      = 32 - MS_PRESHIFT + RECIP_W;

	// One poll as taken from the input channel
	typedef struct packed {
		logic        card;
		logic        sw;
		logic [7:0]  pulses;
		logic [31:0] now;
	} poll_t;

	// Session state carried from poll to poll
	typedef struct packed {
		phase_t      phase;
		logic [10:0] io_reg;
		logic [31:0] tol_start;
		logic [31:0] load_start;
		logic [31:0] good;
		logic [31:0] lost;
	} sess_t;

	// What one poll emits after the status item
	typedef struct packed {
		logic [10:0] io_word;
		logic        snap_io;
		logic        snap_phase;
		logic        load;
		logic [22:0] load_seconds;
	} poll_res_t;

endpackage

// File: rtl/dsc_poll_eval.sv
// Evaluates one poll against the session state: next state and record flags.
// Depends on dsc_pkg.
module dsc_poll_eval (
	input  dsc_pkg::poll_t     poll,
	input  dsc_pkg::sess_t     cur,
	input  logic [15:0]        tolerance_ms,
	output dsc_pkg::sess_t     nxt,
	output dsc_pkg::poll_res_t res
);
	import dsc_pkg::*;

	logic                motor;
	logic [10:0]         new_io;
	logic [31:0]         tol_elapsed;
	logic                tol_wait;
	logic [31:0]         load_elapsed;
	logic [PROD_W-1:0]   prod;
	phase_t              phase_nxt;

	// Build the I/O word
	assign motor  = poll.card | poll.sw;
	assign new_io = {poll.card, poll.sw, 8'd0, motor};

	// Time the tolerance window, modulo 2^32
	assign tol_elapsed = poll.now - cur.tol_start;
	assign tol_wait    = tol_elapsed < {16'd0, tolerance_ms};

	// Seconds of loading by reciprocal multiply
	assign load_elapsed = poll.now - cur.load_start;
	assign prod = PROD_W'(load_elapsed[31:MS_PRESHIFT]) * PROD_W'(RECIP_125);

	// Advance the session phase
	always_comb begin
		phase_nxt = cur.phase;
		unique case (cur.phase)
			PH_NOCARD: begin
				if (poll.card) phase_nxt = PH_DETECTED;
			end
			PH_DETECTED: begin
				phase_nxt = PH_TOLERANCE;
			end
			PH_TOLERANCE: begin
				if (!tol_wait) phase_nxt = poll.card ? PH_LOADING : PH_NOCARD;
			end
			PH_LOADING: begin
				if (!poll.card) phase_nxt = PH_NOCARD;
			end
			default: phase_nxt = PH_NOCARD;
		endcase
	end

	// Drive state updates and record flags
	always_comb begin
		nxt        = cur;
		nxt.phase  = phase_nxt;
		nxt.io_reg = new_io;
		if (motor) begin
			nxt.good = cur.good + 32'(poll.pulses);
		end else begin
			nxt.lost = cur.lost + 32'(poll.pulses);
		end
		if (cur.phase == PH_DETECTED) begin
			nxt.tol_start  = poll.now;
			nxt.load_start = poll.now;
		end
		if (cur.phase == PH_TOLERANCE && !tol_wait && poll.card) begin
			nxt.load_start = poll.now;
		end

		res.io_word      = new_io;
		res.snap_io      = new_io != cur.io_reg;
		res.snap_phase   = (cur.phase == PH_NOCARD && poll.card)
		                || (cur.phase == PH_TOLERANCE && !tol_wait && !poll.card)
		                || (cur.phase == PH_LOADING && !poll.card);
		res.load         = cur.phase == PH_LOADING && !poll.card;
		res.load_seconds = prod[RECIP_SHIFT +: 23];
	end

endmodule

// File: rtl/dispense_session_controller_core.sv
// Top level of the dispense session controller: input stage, poll
// evaluation, record stage and result sequencing. Depends on dsc_pkg, dsc_poll_eval.
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------
//  poll in  | in_valid / in_stall    | card_present switch_active pulses now_ms
//  result   | out_valid / out_stall  | kind io_word motor_on load_seconds tank_id
//           |                        | total_pulses lost_pulses last
//  config   | cfg_valid / cfg_ready  | cfg_index cfg_data
//
// A request lands in the input register, is evaluated into the record register,
// and leaves as one to four results, one per cycle while out_stall is low.
// A new request is taken while the previous poll's results drain.
// Reset clears the session state and restores the configuration defaults.
// A stalled result holds; the input stalls only when both stages are full.
module dispense_session_controller_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        card_present,
	input  logic        switch_active,
	input  logic [7:0]  pulses,
	input  logic [31:0] now_ms,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [10:0] io_word,
	output logic        motor_on,
	output logic [22:0] load_seconds,
	output logic [15:0] tank_id,
	output logic [31:0] total_pulses,
	output logic [31:0] lost_pulses,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import dsc_pkg::*;

	logic [15:0] tolerance_q;
	logic [15:0] tank_q;
	sess_t       sess_q;
	sess_t       sess_nxt;
	poll_res_t   res;

	poll_t       poll_s1;
	logic        valid_s1;

	logic        valid_s2;
	logic        stat_pend_s2;
	logic        snap_io_s2;
	logic        snap_ph_s2;
	logic        load_s2;
	logic [10:0] io_s2;
	logic [22:0] secs_s2;
	logic [15:0] tank_s2;
	logic [31:0] good_s2;
	logic [31:0] lost_s2;

	logic        in_fire;
	logic        out_fire;
	logic        s2_free;
	logic        adv_s1;

	// Configuration writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerance_q <= TOLERANCE_RST;
			tank_q      <= '0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_TOLERANCE) tolerance_q <= cfg_data;
			if (cfg_index == CFG_TANK)      tank_q      <= cfg_data;
		end
	end

	// Stage flow control
	assign out_fire = out_valid && !out_stall;
	assign s2_free  = !valid_s2 || (out_fire && last);
	assign adv_s1   = valid_s1 && s2_free;
	assign in_stall = valid_s1 && !s2_free;
	assign in_fire  = in_valid && !in_stall;

	// Hold the request in the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			poll_s1 <= '{card: card_present, sw: switch_active, pulses: pulses, now: now_ms};
		end
	end

	// Evaluate the poll
	dsc_poll_eval u_eval (
		.poll         (poll_s1),
		.cur          (sess_q),
		.tolerance_ms (tolerance_q),
		.nxt          (sess_nxt),
		.res          (res)
	);

	// Advance the session state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sess_q <= '{phase: PH_NOCARD, default: '0};
		end else if (adv_s1) begin
			sess_q <= sess_nxt;
		end
	end

	// Record stage: pending result flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2     <= 1'b0;
			stat_pend_s2 <= 1'b0;
			snap_io_s2   <= 1'b0;
			snap_ph_s2   <= 1'b0;
			load_s2      <= 1'b0;
		end else if (adv_s1) begin
			valid_s2     <= 1'b1;
			stat_pend_s2 <= 1'b1;
			snap_io_s2   <= res.snap_io;
			snap_ph_s2   <= res.snap_phase;
			load_s2      <= res.load;
		end else if (out_fire) begin
			if (last) begin
				valid_s2 <= 1'b0;
			end else if (stat_pend_s2) begin
				stat_pend_s2 <= 1'b0;
			end else if (snap_io_s2) begin
				snap_io_s2 <= 1'b0;
			end else begin
				snap_ph_s2 <= 1'b0;
			end
		end
	end

	// Record stage: payload
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			io_s2   <= res.io_word;
			secs_s2 <= res.load_seconds;
			tank_s2 <= tank_q;
			good_s2 <= sess_nxt.good;
			lost_s2 <= sess_nxt.lost;
		end
	end

	// Select the current result
	assign out_valid = valid_s2;
	assign io_word   = io_s2;
	assign motor_on  = io_s2[0];

	always_comb begin
		kind         = KIND_LOAD;
		load_seconds = secs_s2;
		tank_id      = tank_s2;
		total_pulses = good_s2;
		lost_pulses  = lost_s2;
		last         = 1'b1;
		priority if (stat_pend_s2) begin
			kind         = KIND_STATUS;
			load_seconds = '0;
			tank_id      = '0;
			total_pulses = '0;
			lost_pulses  = '0;
			last         = !(snap_io_s2 || snap_ph_s2 || load_s2);
		end else if (snap_io_s2 || snap_ph_s2) begin
			kind         = KIND_SNAP;
			load_seconds = '0;
			tank_id      = '0;
			total_pulses = SNAP_FILL;
			lost_pulses  = SNAP_FILL;
			last         = snap_io_s2 ? !(snap_ph_s2 || load_s2) : !load_s2;
		end else begin
			kind = KIND_LOAD;
		end
	end

endmodule
